// ===== hw/rtl/rlt_pkg.sv =====
// Shared types, constants and character-class functions for the rule language tokenizer.
// Used by rlt_scan, rlt_out_queue and rule_language_tokenizer_core. No dependencies.
package rlt_pkg;

   localparam int POS_BITS       = 32;
   localparam int WORD_BITS      = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_TOKEN        = 3'd0,
      ST_END          = 3'd1,
      ST_OPEN_COMMENT = 3'd2,
      ST_OPEN_STRING  = 3'd3,
      ST_BAD_ESCAPE   = 3'd4,
      ST_OPEN_FNAME   = 3'd5,
      ST_BAD_CHARLIT  = 3'd6,
      ST_BAD_CHAR     = 3'd7
   } status_type;

   typedef enum logic [10:0] {
      MODE_IDLE   = 11'b000_0000_0001,
      MODE_SLASH  = 11'b000_0000_0010,
      MODE_BLOCK  = 11'b000_0000_0100,
      MODE_LINE   = 11'b000_0000_1000,
      MODE_STRING = 11'b000_0001_0000,
      MODE_STRESC = 11'b000_0010_0000,
      MODE_FNAME  = 11'b000_0100_0000,
      MODE_CHAR   = 11'b000_1000_0000,
      MODE_COLON  = 11'b001_0000_0000,
      MODE_PREFIX = 11'b010_0000_0000,
      MODE_IDENT  = 11'b100_0000_0000
   } scan_mode_type;

   localparam logic [1:0] LIT_OPEN     = 2'd0;
   localparam logic [1:0] LIT_PLAIN    = 2'd1;
   localparam logic [1:0] LIT_ESC      = 2'd2;
   localparam logic [1:0] LIT_ESC_DONE = 2'd3;

   typedef logic [POS_BITS-1:0] pos_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] token_start;
      logic [WORD_BITS-1:0] token_length;
      status_type           status;
      logic                 last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic         a_vld;
      rsp_item_type a;
      logic         b_vld;
      rsp_item_type b;
   } scan_out_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z") || (c == "_");
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      logic hit;
      case (c) inside
         "!", "~", ".", ",", "(", ")", "{", "}", "$", "@", "=", "<", ">", "|": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic [WORD_BITS-1:0] to_word(pos_type p);
      return WORD_BITS'(p);
   endfunction

endpackage

// ===== hw/rtl/rlt_scan.sv =====
// Scan mode machine: decides one character per cycle while step is high and forms up to two results.
// Depends on rlt_pkg.
module rlt_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           char_code,
   input  logic                 is_end,
   output rlt_pkg::scan_out_type res
);

   rlt_pkg::scan_mode_type mode_ff, mode_in, idle_mode;
   rlt_pkg::pos_type       pos_ff, pos_in, pend_ff, pend_in;
   logic [1:0]             lit_ff, lit_in;
   logic                   star_ff, star_in;
   logic                   halt_ff, halt_in;

   logic                   end_w;
   logic                   use_idle, idle_emit, idle_fail;
   rlt_pkg::status_type    idle_st;
   logic [rlt_pkg::WORD_BITS-1:0] idle_len;
   logic                   fail_v, tok_here;
   rlt_pkg::pos_type       fail_at;
   rlt_pkg::status_type    fail_st;

   assign end_w = is_end | (char_code == 8'd0);

   always_comb begin
      idle_mode = rlt_pkg::MODE_IDLE;
      idle_emit = 1'b0;
      idle_fail = 1'b0;
      idle_st   = rlt_pkg::ST_TOKEN;
      idle_len  = '0;
      if (end_w) begin
         idle_emit = 1'b1;
         idle_st   = rlt_pkg::ST_END;
      end else if (rlt_pkg::is_space(char_code)) begin
         idle_mode = rlt_pkg::MODE_IDLE;
      end else if (char_code == "/") begin
         idle_mode = rlt_pkg::MODE_SLASH;
      end else if (char_code == "#") begin
         idle_mode = rlt_pkg::MODE_LINE;
      end else if (char_code == "\"") begin
         idle_mode = rlt_pkg::MODE_STRING;
      end else if (char_code == "<") begin
         idle_mode = rlt_pkg::MODE_FNAME;
      end else if (char_code == "'") begin
         idle_mode = rlt_pkg::MODE_CHAR;
      end else if (char_code == ":") begin
         idle_mode = rlt_pkg::MODE_COLON;
      end else if (rlt_pkg::is_punct(char_code)) begin
         idle_emit = 1'b1;
         idle_len  = rlt_pkg::WORD_BITS'(1);
      end else if (char_code == "?" || char_code == "-") begin
         idle_mode = rlt_pkg::MODE_PREFIX;
      end else if (rlt_pkg::is_word(char_code)) begin
         idle_mode = rlt_pkg::MODE_IDENT;
      end else begin
         idle_emit = 1'b1;
         idle_fail = 1'b1;
         idle_st   = rlt_pkg::ST_BAD_CHAR;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      pend_in  = pend_ff;
      lit_in   = lit_ff;
      star_in  = star_ff;
      halt_in  = halt_ff;
      res      = '0;
      use_idle = 1'b0;
      fail_v   = 1'b0;
      fail_at  = pos_ff;
      fail_st  = rlt_pkg::ST_BAD_CHAR;
      tok_here = 1'b0;
      if (step && !halt_ff) begin
         unique case (mode_ff)
            rlt_pkg::MODE_SLASH: begin
               if (!end_w && char_code == "*") begin
                  mode_in = rlt_pkg::MODE_BLOCK;
                  star_in = 1'b1;
               end else begin
                  fail_v  = 1'b1;
                  fail_at = pend_ff;
               end
            end
            rlt_pkg::MODE_BLOCK: begin
               if (star_ff && !end_w && char_code == "/") begin
                  mode_in = rlt_pkg::MODE_IDLE;
                  star_in = 1'b0;
               end else if (end_w) begin
                  fail_v  = 1'b1;
                  fail_st = rlt_pkg::ST_OPEN_COMMENT;
               end else begin
                  star_in = (char_code == "*");
               end
            end
            rlt_pkg::MODE_LINE: begin
               if (end_w) begin
                  use_idle = 1'b1;
               end else if (char_code == 8'd13 || char_code == 8'd10) begin
                  mode_in = rlt_pkg::MODE_IDLE;
               end
            end
            rlt_pkg::MODE_STRING: begin
               if (end_w) begin
                  fail_v  = 1'b1;
                  fail_st = rlt_pkg::ST_OPEN_STRING;
               end else if (char_code == "\"") begin
                  tok_here = 1'b1;
               end else if (char_code == "\\") begin
                  mode_in = rlt_pkg::MODE_STRESC;
               end
            end
            rlt_pkg::MODE_STRESC: begin
               if (end_w) begin
                  fail_v  = 1'b1;
                  fail_st = rlt_pkg::ST_OPEN_STRING;
               end else if (char_code == "\\" || char_code == "\"") begin
                  mode_in = rlt_pkg::MODE_STRING;
               end else begin
                  fail_v  = 1'b1;
                  fail_st = rlt_pkg::ST_BAD_ESCAPE;
               end
            end
            rlt_pkg::MODE_FNAME: begin
               if (end_w) begin
                  fail_v  = 1'b1;
                  fail_st = rlt_pkg::ST_OPEN_FNAME;
               end else if (char_code == ">") begin
                  tok_here = 1'b1;
               end
            end
            rlt_pkg::MODE_CHAR: begin
               fail_at = pend_ff;
               unique case (lit_ff)
                  rlt_pkg::LIT_OPEN: begin
                     if (end_w) begin
                        fail_v  = 1'b1;
                        fail_st = rlt_pkg::ST_BAD_CHARLIT;
                     end else if (char_code == "'") begin
                        tok_here = 1'b1;
                     end else if (char_code == "\\") begin
                        lit_in = rlt_pkg::LIT_ESC;
                     end else begin
                        lit_in = rlt_pkg::LIT_PLAIN;
                     end
                  end
                  rlt_pkg::LIT_PLAIN: begin
                     if (!end_w && char_code == "'") begin
                        tok_here = 1'b1;
                     end else begin
                        fail_v  = 1'b1;
                        fail_st = rlt_pkg::ST_BAD_CHARLIT;
                     end
                  end
                  rlt_pkg::LIT_ESC: begin
                     if (!end_w && (char_code == "\\" || char_code == "'" ||
                                    char_code == "r" || char_code == "n" ||
                                    char_code == "t")) begin
                        lit_in = rlt_pkg::LIT_ESC_DONE;
                     end else begin
                        fail_v  = 1'b1;
                        fail_st = rlt_pkg::ST_BAD_ESCAPE;
                     end
                  end
                  default: begin
                     if (!end_w && char_code == "'") begin
                        tok_here = 1'b1;
                     end else begin
                        fail_v  = 1'b1;
                        fail_st = rlt_pkg::ST_BAD_ESCAPE;
                     end
                  end
               endcase
            end
            rlt_pkg::MODE_COLON: begin
               if (!end_w && (char_code == "-" || char_code == "=")) begin
                  tok_here = 1'b1;
               end else begin
                  fail_v = 1'b1;
               end
            end
            rlt_pkg::MODE_PREFIX: begin
               if (!end_w && rlt_pkg::is_word(char_code)) begin
                  mode_in = rlt_pkg::MODE_IDENT;
               end else begin
                  fail_v = 1'b1;
               end
            end
            rlt_pkg::MODE_IDENT: begin
               if (end_w || !rlt_pkg::is_word(char_code)) begin
                  res.a_vld              = 1'b1;
                  res.a.token_start      = rlt_pkg::to_word(pend_ff);
                  res.a.token_length     = rlt_pkg::to_word(pos_ff - pend_ff);
                  res.a.status           = rlt_pkg::ST_TOKEN;
                  use_idle               = 1'b1;
               end
            end
            default: begin
               use_idle = 1'b1;
            end
         endcase

         if (use_idle) begin
            mode_in = idle_mode;
            if (!end_w) begin
               pend_in = pos_ff;
            end
            if (idle_mode == rlt_pkg::MODE_CHAR) begin
               lit_in = rlt_pkg::LIT_OPEN;
            end
            if (idle_emit) begin
               res.b_vld          = 1'b1;
               res.b.token_start  = rlt_pkg::to_word(pos_ff);
               res.b.token_length = idle_len;
               res.b.status       = idle_st;
            end
            if (idle_fail) begin
               halt_in = 1'b1;
               mode_in = rlt_pkg::MODE_IDLE;
            end
         end

         if (fail_v) begin
            res.b_vld          = 1'b1;
            res.b.token_start  = rlt_pkg::to_word(fail_at);
            res.b.token_length = '0;
            res.b.status       = fail_st;
            halt_in            = 1'b1;
            mode_in            = rlt_pkg::MODE_IDLE;
         end

         if (tok_here) begin
            res.b_vld          = 1'b1;
            res.b.token_start  = rlt_pkg::to_word(pend_ff);
            res.b.token_length = rlt_pkg::to_word(pos_ff + 1'b1 - pend_ff);
            res.b.status       = rlt_pkg::ST_TOKEN;
            mode_in            = rlt_pkg::MODE_IDLE;
         end

         if (mode_ff == rlt_pkg::MODE_CHAR && mode_in != rlt_pkg::MODE_CHAR) begin
            lit_in = rlt_pkg::LIT_OPEN;
         end

         res.a.last_of_run = !res.b_vld;
         res.b.last_of_run = 1'b1;

         if (end_w) begin
            if (!halt_in) begin
               mode_in = rlt_pkg::MODE_IDLE;
               pos_in  = '0;
               pend_in = '0;
               lit_in  = rlt_pkg::LIT_OPEN;
               star_in = 1'b0;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rlt_pkg::MODE_IDLE;
         pos_ff  <= '0;
         pend_ff <= '0;
         lit_ff  <= rlt_pkg::LIT_OPEN;
         star_ff <= 1'b0;
         halt_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         lit_ff  <= lit_in;
         star_ff <= star_in;
         halt_ff <= halt_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !res.a_vld && !res.b_vld)
      else $error("result produced while halted");

   a_flush_from_ident: assert property (@(posedge clock) disable iff (reset)
      res.a_vld |-> mode_ff == rlt_pkg::MODE_IDENT)
      else $error("identifier flush outside identifier mode");

   a_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      step && end_w && !halt_in |=> pos_ff == '0 && mode_ff == rlt_pkg::MODE_IDLE)
      else $error("end of text did not rewind the scanner");

endmodule

// ===== hw/rtl/rlt_out_queue.sv =====
// Small result queue: takes up to two results per cycle while it has room, hands out one per cycle on pop.
// Depends on rlt_pkg.
module rlt_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  rlt_pkg::scan_out_type push,
   input  logic                  pop,
   output logic                  room,
   output logic                  not_empty,
   output rlt_pkg::rsp_item_type head
);

   rlt_pkg::rsp_item_type mem [rlt_pkg::QUEUE_DEPTH];

   logic [rlt_pkg::QUEUE_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_b;
   logic [rlt_pkg::QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]                         push_n;

   assign push_n    = 2'(push.a_vld) + 2'(push.b_vld);
   assign wr_b      = push.a_vld ? wr_ff + 1'b1 : wr_ff;
   assign room      = cnt_ff <= rlt_pkg::QUEUE_CNT_BITS'(rlt_pkg::QUEUE_DEPTH - 2);
   assign not_empty = cnt_ff != '0;
   assign head      = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff + rlt_pkg::QUEUE_PTR_BITS'(push_n);
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + rlt_pkg::QUEUE_CNT_BITS'(push_n) - rlt_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.a_vld) begin
         mem[wr_ff] <= push.a;
      end
      if (push.b_vld) begin
         mem[wr_b] <= push.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> room)
      else $error("push without room");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= rlt_pkg::QUEUE_CNT_BITS'(rlt_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== hw/rtl/rule_language_tokenizer_core.sv =====
// Top level of the rule language tokenizer: scanner plus result queue.
// Depends on rlt_pkg, rlt_scan and rlt_out_queue.
//
// Usage:
//   req_ channel carries one character (req_char_code) or an end mark
//   (req_is_end, or code 0) per transaction. rsp_ channel carries token
//   spans: start offset, length, status and last_of_run, which flags the
//   final result caused by one request.
//   A request is decided in the cycle it is accepted; its results are
//   registered into a four-entry queue that drives rsp_.
//   Throughput is one request per cycle while req_stall is low; a request
//   that yields two results (an identifier closed by punctuation, an error
//   or an end mark) fills two entries for the single-result output port.
//   req_stall rises when fewer than two queue entries are free, so a
//   stalled receiver backs up into the request side after a few results.
//   An error result halts the scanner: later requests are accepted and
//   dropped until reset. Reset empties the queue, sets offset zero and
//   returns the scanner to idle between tokens.
module rule_language_tokenizer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_char_code,
   input  logic                               req_is_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rlt_pkg::WORD_BITS-1:0]      rsp_token_start,
   output logic [rlt_pkg::WORD_BITS-1:0]      rsp_token_length,
   output logic [2:0]                         rsp_status,
   output logic                               rsp_last_of_run
);

   logic                  step, room, pop;
   rlt_pkg::scan_out_type res;
   rlt_pkg::rsp_item_type head;

   assign req_stall = !room;
   assign step      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   rlt_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (req_char_code),
      .is_end    (req_is_end),
      .res       (res)
   );

   rlt_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res),
      .pop       (pop),
      .room      (room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_token_start  = head.token_start;
   assign rsp_token_length = head.token_length;
   assign rsp_status       = head.status;
   assign rsp_last_of_run  = head.last_of_run;

endmodule
